FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module rled_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/rled_pkg.sv
package rled_pkg;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_ZERO_SIZE = 3'd1;
	localparam logic [2:0] ERR_ZERO_CNT  = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_DATA_END  = 3'd4;

	localparam logic [1:0] REG_TONE_TOP  = 2'd0;
	localparam logic [1:0] REG_INVERT    = 2'd1;
	localparam logic [1:0] REG_TRANSP    = 2'd2;

	localparam logic [3:0] COLOR_MAX     = 4'hf;
	localparam logic [4:0] DIV_STEPS     = 5'd16;

	// x / 15 equals (x * 137) >> 11 for every x up to 225.
	localparam logic [15:0] TONE_RECIP   = 16'd137;
	localparam int          TONE_SHIFT   = 11;

	typedef struct packed {
		logic take;
		logic div_start;
		logic load_out;
	} rled_cmd_t;

	typedef struct packed {
		logic has_result;
		logic needs_div;
		logic div_done;
		logic out_free;
	} rled_sts_t;

	function automatic logic [3:0] tone_map(input logic [3:0] color, input logic [3:0] top,
		input logic inv);
		logic [3:0]  src;
		logic [7:0]  prod;
		logic [15:0] scaled;
		src    = inv ? (COLOR_MAX - color) : color;
		prod   = {4'd0, src} * {4'd0, top};
		scaled = {8'd0, prod} * TONE_RECIP;
		return scaled[TONE_SHIFT +: 4];
	endfunction

endpackage

FILE: rtl/core/rled_div.sv
module rled_div import rled_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [15:0] quotient,
	output logic [7:0]  remainder
);

	logic [4:0]  cnt_q;
	logic [15:0] quo_q;
	logic [7:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [8:0]  trial;
	logic [8:0]  diff;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[14:0], fits};
			rem_q <= fits ? diff[7:0] : trial[7:0];
		end
	end

	assign done      = cnt_q == '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/core/rled_dp.sv
module rled_dp import rled_pkg::*; #(
	parameter int CACHE_BYTES = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rled_cmd_t   cmd,
	output rled_sts_t   sts,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int SUM_W = 19;
	localparam int CMP_W = ($clog2(CACHE_BYTES + 1) > SUM_W) ? $clog2(CACHE_BYTES + 1) : SUM_W;

	typedef enum logic [1:0] {
		PH_WIDTH,
		PH_HEIGHT,
		PH_TOKEN
	} ph_t;

	ph_t         phase_q, nxt_phase;
	logic [7:0]  width_q, nxt_width;
	logic [15:0] left_q, nxt_left;
	logic [15:0] index_q, nxt_index;
	logic [1:0]  seen_q, nxt_seen;
	logic [7:0]  partial_q, nxt_partial;
	logic [3:0]  color_q, nxt_color;
	logic [17:0] total_q, nxt_total;

	logic [3:0]  tone_top_q;
	logic        invert_q;
	logic        transp_q;

	logic        pnd_run_q;
	logic [3:0]  pnd_color_q;
	logic        pnd_hidden_q;
	logic [15:0] pnd_len_q;
	logic        pnd_done_q;
	logic [17:0] pnd_bytes_q;
	logic [2:0]  pnd_err_q;

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        out_run_q;
	logic        out_last_q;

	logic        res;
	logic        run;
	logic        fin;
	logic        err_hit;
	logic        tok_done;
	logic        eod;
	logic        bound_hit;
	logic [2:0]  err;
	logic [15:0] count;
	logic [2:0]  used;
	logic [3:0]  tok_color;
	logic [15:0] area;
	logic [SUM_W-1:0] bound_sum;

	logic        div_done;
	logic [15:0] div_quo;
	logic [7:0]  div_rem;

	rled_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (index_q),
		.divisor   (width_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign bound_sum = {1'b0, total_q} + {17'd0, seen_q} + SUM_W'(3);
	assign bound_hit = CMP_W'(bound_sum) >= CMP_W'(CACHE_BYTES);
	assign area      = {8'd0, width_q} * {8'd0, s_tdata};
	assign tok_color = (seen_q == 2'd0) ? s_tdata[3:0] : color_q;

	always_comb begin
		nxt_phase   = phase_q;
		nxt_width   = width_q;
		nxt_left    = left_q;
		nxt_index   = index_q;
		nxt_seen    = seen_q;
		nxt_partial = partial_q;
		nxt_color   = color_q;
		nxt_total   = total_q;
		res         = 1'b0;
		run         = 1'b0;
		fin         = 1'b0;
		err_hit     = 1'b0;
		tok_done    = 1'b0;
		err         = ERR_NONE;
		count       = '0;
		used        = '0;
		eod         = s_tlast || (phase_q == PH_TOKEN && bound_hit);
		case (phase_q)
			PH_WIDTH: begin
				nxt_width = s_tdata;
				if (s_tlast) begin
					err_hit = 1'b1;
					err     = ERR_DATA_END;
				end else begin
					nxt_phase = PH_HEIGHT;
				end
			end
			PH_HEIGHT: begin
				if (width_q == '0 || s_tdata == '0) begin
					err_hit = 1'b1;
					err     = ERR_ZERO_SIZE;
				end else if (s_tlast) begin
					err_hit = 1'b1;
					err     = ERR_DATA_END;
				end else begin
					nxt_left    = area;
					nxt_index   = '0;
					nxt_total   = '0;
					nxt_seen    = '0;
					nxt_partial = '0;
					nxt_phase   = PH_TOKEN;
				end
			end
			PH_TOKEN: begin
				case (seen_q)
					2'd0: begin
						nxt_color = s_tdata[3:0];
						if (s_tdata[7:4] != '0) begin
							count    = {12'd0, s_tdata[7:4]};
							used     = 3'd1;
							tok_done = 1'b1;
						end
					end
					2'd1: begin
						if (s_tdata != '0) begin
							count    = {8'd0, s_tdata};
							used     = 3'd2;
							tok_done = 1'b1;
						end
					end
					2'd2: begin
						nxt_partial = s_tdata;
					end
					default: begin
						count = {s_tdata, partial_q};
						if (count == '0) begin
							err_hit = 1'b1;
							err     = ERR_ZERO_CNT;
						end else begin
							used     = 3'd4;
							tok_done = 1'b1;
						end
					end
				endcase
				if (!err_hit) begin
					if (!tok_done) begin
						if (eod) begin
							err_hit = 1'b1;
							err     = ERR_DATA_END;
						end else begin
							nxt_seen = seen_q + 2'd1;
						end
					end else if (count > left_q) begin
						err_hit = 1'b1;
						err     = ERR_OVERFLOW;
					end else begin
						res         = 1'b1;
						run         = 1'b1;
						nxt_total   = total_q + {15'd0, used};
						nxt_left    = left_q - count;
						nxt_index   = index_q + count;
						nxt_seen    = '0;
						nxt_partial = '0;
						if (nxt_left == '0) begin
							fin       = 1'b1;
							nxt_phase = PH_WIDTH;
						end else if (eod) begin
							err       = ERR_DATA_END;
							nxt_phase = PH_WIDTH;
						end
					end
				end
			end
			default: begin
				nxt_phase = PH_WIDTH;
			end
		endcase
		if (err_hit) begin
			res         = 1'b1;
			run         = 1'b0;
			nxt_phase   = PH_WIDTH;
			nxt_seen    = '0;
			nxt_partial = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WIDTH;
			width_q     <= '0;
			left_q      <= '0;
			index_q     <= '0;
			seen_q      <= '0;
			partial_q   <= '0;
			color_q     <= '0;
			total_q     <= '0;
			tone_top_q  <= COLOR_MAX;
			invert_q    <= 1'b0;
			transp_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				phase_q   <= nxt_phase;
				width_q   <= nxt_width;
				left_q    <= nxt_left;
				index_q   <= nxt_index;
				seen_q    <= nxt_seen;
				partial_q <= nxt_partial;
				color_q   <= nxt_color;
				total_q   <= nxt_total;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_TONE_TOP: tone_top_q <= cfg_data;
					REG_INVERT:   invert_q   <= cfg_data[0];
					REG_TRANSP:   transp_q   <= cfg_data[0];
					default:      ;
				endcase
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && res) begin
			pnd_run_q    <= run;
			pnd_color_q  <= run ? tone_map(tok_color, tone_top_q, invert_q) : 4'd0;
			pnd_hidden_q <= run && transp_q && tok_color == 4'd0;
			pnd_len_q    <= run ? count : 16'd0;
			pnd_done_q   <= fin;
			pnd_bytes_q  <= fin ? nxt_total : 18'd0;
			pnd_err_q    <= err;
		end
		if (cmd.load_out) begin
			out_run_q  <= pnd_run_q;
			out_last_q <= pnd_done_q;
			out_data_q <= {6'd0, pnd_err_q, pnd_bytes_q,
				pnd_run_q ? div_quo[7:0] : 8'd0,
				pnd_run_q ? div_rem : 8'd0,
				pnd_len_q, pnd_hidden_q, pnd_color_q};
		end
	end

	assign sts.has_result = res;
	assign sts.needs_div  = run;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_run_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/core/rled_ctrl.sv
module rled_ctrl import rled_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  rled_sts_t sts,
	output rled_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q, nxt_state;
	logic   rdy_q;

	always_comb begin
		nxt_state     = state_q;
		cmd.take      = s_tvalid && rdy_q;
		cmd.div_start = 1'b0;
		cmd.load_out  = 1'b0;
		case (state_q)
			ST_ACCEPT: begin
				if (cmd.take && sts.has_result) begin
					if (sts.needs_div) begin
						cmd.div_start = 1'b1;
						nxt_state     = ST_DIV;
					end else begin
						nxt_state = ST_EMIT;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					nxt_state = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					nxt_state    = ST_ACCEPT;
				end
			end
			default: begin
				nxt_state = ST_ACCEPT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= nxt_state;
			rdy_q   <= nxt_state == ST_ACCEPT;
		end
	end

	assign s_tready = rdy_q;

endmodule

FILE: rtl/core/rle_4bpp_image_decoder.sv
// Decodes a cached 4-bit-per-pixel run-length image that arrives one byte per word: width,
// height, then run tokens of one, two or four bytes. Each finished token gives one output
// word with the tone-mapped color, hidden flag, length and start column and row; the word
// that completes the image has tlast set and carries the token byte total. Errors give
// a word with only the error code, except a run cut off by the end of the data, which
// carries the code in its run word. A byte that completes a run is accepted, then the
// bit-serial divider splits the pixel index into row and column, the controller sees the
// divider finish, and the result moves into the output register once it is free. An error
// word skips the divider. The output register holds a finished word while the next byte is
// taken in. There is no clearing pass after reset.
module rle_4bpp_image_decoder import rled_pkg::*; #(
	parameter int CACHE_BYTES = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] run_color, [4] run_hidden, [20:5] run_length, [28:21] start_col,
	// [36:29] start_row, [54:37] bytes_used, [57:55] error_code, [63:58] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser,  // [0] has_run
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	rled_cmd_t cmd;
	rled_sts_t sts;

	assign cfg_ready = 1'b1;

	rled_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rled_dp #(
		.CACHE_BYTES (CACHE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: rtl/core/rled_chk.sv
`include "assert_macros.svh"

module rled_chk import rled_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic        stall;
	logic        bare_ok;
	logic        last_ok;
	logic [17:0] bytes_f;
	logic [2:0]  code_f;

	assign bytes_f = m_tdata[54:37];
	assign code_f  = m_tdata[57:55];
	assign stall   = m_tvalid && !m_tready;
	assign bare_ok = !m_tlast && code_f != ERR_NONE && m_tdata[54:0] == '0;
	assign last_ok = m_tuser && code_f == ERR_NONE && bytes_f != '0;

	`ASSERT_NEXT(a_word_holds, clk, arst_n, stall, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

	`ASSERT_SAME(a_error_word_bare, clk, arst_n, m_tvalid && !m_tuser, bare_ok)

	`ASSERT_SAME(a_last_word_clean, clk, arst_n, m_tvalid && m_tlast, last_ok)

	`ASSERT_SAME(a_bytes_on_last_only, clk, arst_n, m_tvalid && !m_tlast, bytes_f == '0)

endmodule

bind rle_4bpp_image_decoder rled_chk u_rled_chk (.*);
